// ===== hw/rtl/pcs_pkg.sv =====
package pcs_pkg;

	localparam int unsigned AdcW     = 10;
	localparam int unsigned TimeW    = 32;
	localparam int unsigned PpW      = 11;
	localparam int unsigned CountW   = 8;
	localparam int unsigned TmoW     = 21;
	localparam int unsigned CfgIdxW  = 2;
	localparam int unsigned CfgDataW = 21;
	localparam int unsigned InDataW  = 48;
	localparam int unsigned FuncW    = 3;
	localparam int unsigned OutDataW = 24;

	localparam logic [PpW-1:0]    PpThresholdReset = 11'd100;
	localparam logic [CountW-1:0] FailLimitReset   = 8'd3;
	localparam logic [CountW-1:0] CountMax         = 8'd255;

	typedef enum logic [CfgIdxW-1:0] {
		CFG_PP_THRESHOLD   = 2'd0,
		CFG_FAIL_LIMIT     = 2'd1,
		CFG_TIMEOUT_MANUAL = 2'd2,
		CFG_TIMEOUT_AUTO   = 2'd3
	} cfg_idx_t;

	typedef enum logic [FuncW-1:0] {
		FN_SAMPLE       = 3'd0,
		FN_TICK         = 3'd1,
		FN_MANUAL_START = 3'd2,
		FN_MANUAL_STOP  = 3'd3,
		FN_AUTO_START   = 3'd4,
		FN_AUTO_STOP    = 3'd5,
		FN_DISABLE      = 3'd6,
		FN_ENABLE       = 3'd7
	} func_t;

	typedef enum logic [2:0] {
		EV_NONE     = 3'd0,
		EV_STARTED  = 3'd1,
		EV_STOPPED  = 3'd2,
		EV_EMERG    = 3'd3,
		EV_DISABLED = 3'd4,
		EV_ENABLED  = 3'd5
	} event_t;

	typedef enum logic [2:0] {
		ERR_NONE       = 3'd0,
		ERR_TIMEOUT    = 3'd1,
		ERR_NO_CURRENT = 3'd2,
		ERR_STRAY      = 3'd3,
		ERR_DISABLED   = 3'd4
	} error_t;

	typedef struct packed {
		logic [PpW-1:0] peak_to_peak;
		error_t         error;
		event_t         event_res;
		logic           system_disabled;
		logic           pump_on;
	} result_t;

endpackage

// ===== hw/rtl/pump_current_supervisor_top.sv =====
// Pump current supervisor.
// Input stream (s_*): one command or measurement per transfer. s_tuser carries
// the command code (sample, second tick, manual/auto start and stop, disable,
// enable); s_tdata carries the ADC reading and the clock seconds.
// Output stream (m_*): exactly one result per input transfer, in order, with
// relay states, event code, error code and the window peak-to-peak on ticks.
// Configuration: write cfg_wdata to register cfg_index while cfg_we is high;
// 0 peak-to-peak threshold, 1 fault limit, 2 manual and 3 auto run timeout.
// The result passes the input register, then the result register. Throughput:
// one item per cycle while the receiver takes results, set by the single
// pass of compare-and-update logic between the two registers.
// Reset clears the relays, fault counters, window and both stream stages and
// loads the register defaults (threshold 100, limit 3, timeouts disabled).
// When the receiver stalls, the result register holds; one more item waits
// in the input register and s_tready drops until the result is taken.
module pump_current_supervisor_top (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	// adc_sample [9:0], now_seconds [41:10], zero fill [47:42]
	input  logic [pcs_pkg::InDataW-1:0]   s_tdata,
	// func [2:0]
	input  logic [pcs_pkg::FuncW-1:0]     s_tuser,
	output logic                          m_tvalid,
	input  logic                          m_tready,
	// pump_on [0], system_disabled [1], event_res [4:2], error [7:5],
	// peak_to_peak [18:8], zero fill [23:19]
	output logic [pcs_pkg::OutDataW-1:0]  m_tdata,
	input  logic                          cfg_we,
	input  logic [pcs_pkg::CfgIdxW-1:0]   cfg_index,
	input  logic [pcs_pkg::CfgDataW-1:0]  cfg_wdata
);
	import pcs_pkg::*;

	logic [PpW-1:0]    pp_threshold_q;
	logic [CountW-1:0] fail_limit_q;
	logic [TmoW-1:0]   tmo_manual_q;
	logic [TmoW-1:0]   tmo_auto_q;

	logic              valid_s1;
	func_t             func_s1;
	logic [AdcW-1:0]   adc_s1;
	logic [TimeW-1:0]  now_s1;

	logic              running_q, disabled_q, manual_q, alarm_q;
	logic [TimeW-1:0]  start_q;
	logic signed [PpW-1:0] wmax_q, wmin_q;
	logic [CountW-1:0] nc_q, stray_q, dc_q;

	logic              nx_running, nx_disabled, nx_manual, nx_alarm;
	logic [TimeW-1:0]  nx_start;
	logic signed [PpW-1:0] nx_wmax, nx_wmin;
	logic [CountW-1:0] nx_nc, nx_stray, nx_dc;

	logic              m_valid_q;
	result_t           res_q, res;
	logic              adv;
	logic signed [PpW-1:0] centred;
	logic [TmoW-1:0]   tmo_lim;
	logic [TimeW-1:0]  elapsed;
	logic              tmo_hit;
	logic [PpW-1:0]    pp_w;
	event_t            ev;
	error_t            err;

	function automatic logic [CountW-1:0] bump(input logic [CountW-1:0] c);
		return (c == CountMax) ? c : c + CountW'(1);
	endfunction

	assign adv      = valid_s1 && (!m_valid_q || m_tready);
	assign s_tready = !valid_s1 || adv;
	assign m_tvalid = m_valid_q;
	assign m_tdata  = {(OutDataW - $bits(result_t))'(0), res_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pp_threshold_q <= PpThresholdReset;
			fail_limit_q   <= FailLimitReset;
			tmo_manual_q   <= '1;
			tmo_auto_q     <= '1;
		end else if (cfg_we) begin
			unique case (cfg_idx_t'(cfg_index))
				CFG_PP_THRESHOLD:   pp_threshold_q <= cfg_wdata[PpW-1:0];
				CFG_FAIL_LIMIT:     fail_limit_q   <= cfg_wdata[CountW-1:0];
				CFG_TIMEOUT_MANUAL: tmo_manual_q   <= cfg_wdata[TmoW-1:0];
				CFG_TIMEOUT_AUTO:   tmo_auto_q     <= cfg_wdata[TmoW-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			func_s1 <= func_t'(s_tuser);
			adc_s1  <= s_tdata[AdcW-1:0];
			now_s1  <= s_tdata[AdcW +: TimeW];
		end
	end

	assign centred = {~adc_s1[AdcW-1], adc_s1[AdcW-2:0], 1'b1};
	assign tmo_lim = manual_q ? tmo_manual_q : tmo_auto_q;
	assign elapsed = now_s1 - start_q;
	assign tmo_hit = !disabled_q && running_q && !tmo_lim[TmoW-1]
		&& (elapsed > {(TimeW - TmoW)'(0), tmo_lim});
	assign pp_w    = PpW'(wmax_q - wmin_q);

	always_comb begin
		nx_running  = running_q;
		nx_disabled = disabled_q;
		nx_manual   = manual_q;
		nx_alarm    = alarm_q;
		nx_start    = start_q;
		nx_wmax     = wmax_q;
		nx_wmin     = wmin_q;
		nx_nc       = nc_q;
		nx_stray    = stray_q;
		nx_dc       = dc_q;
		ev          = EV_NONE;
		err         = ERR_NONE;
		res.peak_to_peak = '0;

		if ((func_s1 == FN_SAMPLE || func_s1 == FN_TICK) && tmo_hit) begin
			nx_disabled = 1'b1;
			nx_running  = 1'b0;
			ev          = EV_EMERG;
			err         = ERR_TIMEOUT;
		end

		unique case (func_s1)
			FN_SAMPLE: begin
				if (centred > wmax_q) nx_wmax = centred;
				if (centred < wmin_q) nx_wmin = centred;
			end
			FN_TICK: begin
				res.peak_to_peak = pp_w;
				if (!nx_disabled) begin
					nx_alarm = 1'b0;
					if (nx_running)
						nx_nc = (pp_w < pp_threshold_q) ? bump(nc_q) : '0;
					else
						nx_stray = (pp_w > pp_threshold_q) ? bump(stray_q) : '0;
					if (nx_nc > fail_limit_q) begin
						nx_disabled = 1'b1;
						nx_running  = 1'b0;
						nx_nc       = '0;
						if (ev == EV_NONE) ev = EV_DISABLED;
						if (err == ERR_NONE) err = ERR_NO_CURRENT;
					end
					if (nx_stray > fail_limit_q) begin
						nx_stray = '0;
						if (err == ERR_NONE) err = ERR_STRAY;
					end
				end else if (!alarm_q) begin
					nx_dc = (pp_w > pp_threshold_q) ? bump(dc_q) : '0;
					if (nx_dc > fail_limit_q) begin
						nx_dc    = '0;
						nx_alarm = 1'b1;
						if (err == ERR_NONE) err = ERR_DISABLED;
					end
				end
				nx_wmax = '0;
				nx_wmin = '0;
			end
			FN_MANUAL_START, FN_AUTO_START: begin
				if (!disabled_q && !running_q) begin
					nx_running = 1'b1;
					nx_manual  = (func_s1 == FN_MANUAL_START);
					nx_start   = now_s1;
					ev         = EV_STARTED;
				end
			end
			FN_MANUAL_STOP, FN_AUTO_STOP: begin
				if (!disabled_q && running_q) begin
					nx_running = 1'b0;
					ev         = EV_STOPPED;
				end
			end
			FN_DISABLE: begin
				nx_disabled = 1'b1;
				nx_running  = 1'b0;
				ev          = EV_DISABLED;
			end
			FN_ENABLE: begin
				nx_disabled = 1'b0;
				ev          = EV_ENABLED;
			end
			default: ;
		endcase

		res.pump_on         = nx_running;
		res.system_disabled = nx_disabled;
		res.event_res       = ev;
		res.error           = err;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			running_q  <= 1'b0;
			disabled_q <= 1'b0;
			manual_q   <= 1'b0;
			alarm_q    <= 1'b0;
			start_q    <= '0;
			wmax_q     <= '0;
			wmin_q     <= '0;
			nc_q       <= '0;
			stray_q    <= '0;
			dc_q       <= '0;
			m_valid_q  <= 1'b0;
		end else if (adv) begin
			running_q  <= nx_running;
			disabled_q <= nx_disabled;
			manual_q   <= nx_manual;
			alarm_q    <= nx_alarm;
			start_q    <= nx_start;
			wmax_q     <= nx_wmax;
			wmin_q     <= nx_wmin;
			nc_q       <= nx_nc;
			stray_q    <= nx_stray;
			dc_q       <= nx_dc;
			m_valid_q  <= 1'b1;
		end else if (m_tready) begin
			m_valid_q  <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) res_q <= res;
	end

endmodule

// ===== hw/rtl/pcs_check.sv =====
module pcs_check (
	input logic                         clk,
	input logic                         arst_n,
	input logic                         m_tvalid,
	input logic                         m_tready,
	input logic [pcs_pkg::OutDataW-1:0] m_tdata
);
	import pcs_pkg::*;

	result_t r;
	assign r = result_t'(m_tdata[$bits(result_t)-1:0]);

	// hold a stalled result
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("stalled result changed");

	a_reset_idle: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(arst_n) |-> !m_tvalid)
		else $error("result valid right after reset");

	a_relay_event: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (r.event_res != EV_STARTED || r.pump_on)
			&& ((r.event_res != EV_STOPPED && r.event_res != EV_EMERG
				&& r.event_res != EV_DISABLED) || !r.pump_on))
		else $error("pump relay disagrees with event");

	a_disable_event: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> ((r.event_res != EV_EMERG && r.event_res != EV_DISABLED)
				|| r.system_disabled)
			&& (r.event_res != EV_ENABLED || !r.system_disabled))
		else $error("disable relay disagrees with event");

	a_pp_tick: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (r.peak_to_peak != '0) |-> r.event_res == EV_NONE
			|| r.event_res == EV_EMERG || r.event_res == EV_DISABLED)
		else $error("peak-to-peak on a non-tick result");

endmodule

bind pump_current_supervisor_top pcs_check u_pcs_check (.*);
